>>> rtl/tnrp_pkg.sv
// tnrp_pkg: shared codes, result types and helpers of the telnet receive parser
`timescale 1ns / 1ps
package tnrp_pkg;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_GA   = 8'd249;
  localparam logic [7:0] B_AYT  = 8'd246;
  localparam logic [7:0] B_DM   = 8'd242;
  localparam logic [7:0] B_SE   = 8'd240;

  // result kinds
  localparam logic [2:0] K_DATA  = 3'd0;
  localparam logic [2:0] K_REPLY = 3'd1;
  localparam logic [2:0] K_EVENT = 3'd2;
  localparam logic [2:0] K_AYT   = 3'd3;
  localparam logic [2:0] K_SBYTE = 3'd4;
  localparam logic [2:0] K_SEND  = 3'd5;
  localparam logic [2:0] K_ERR   = 3'd6;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_BADSB    = 3'd1;
  localparam logic [2:0] E_GA       = 3'd2;
  localparam logic [2:0] E_UNKNOWN  = 3'd3;
  localparam logic [2:0] E_OVERFLOW = 3'd4;
  localparam logic [2:0] E_STRAY    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_REGISTERED = 3'd0;
  localparam logic [2:0] REG_LOCAL_SUP  = 3'd1;
  localparam logic [2:0] REG_REMOTE_SUP = 3'd2;
  localparam logic [2:0] REG_SUBNEG_SUP = 3'd3;
  localparam logic [2:0] REG_SUBNEG_LIM = 3'd4;
  localparam logic [2:0] REG_CMD_EVENTS = 3'd5;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] reply;
    logic [2:0] err;
  } res_t;

  // all results caused by one byte
  typedef struct packed {
    logic [1:0]          cnt;
    res_t [MAX_RES-1:0]  item;
  } bundle_t;

  typedef struct packed {
    logic [63:0] registered;
    logic [63:0] local_sup;
    logic [63:0] remote_sup;
    logic [63:0] subneg_sup;
    logic [11:0] subneg_lim;
    logic [15:0] cmd_events;
  } cfg_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] value,
                                  logic [7:0] reply, logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.reply = reply;
    r.err   = err;
    return r;
  endfunction

endpackage

>>> rtl/tnrp_opt_mem.sv
// tnrp_opt_mem: per-option enabled table, registered read with write forwarding
`timescale 1ns / 1ps
module tnrp_opt_mem
  import tnrp_pkg::*;
#(
  parameter int NUM_OPTIONS = 64,
  parameter int IDX_W = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [1:0]       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [1:0]       wr_data
);

  logic [1:0]             mem [NUM_OPTIONS];
  logic [NUM_OPTIONS-1:0] vld_r;
  logic [1:0]             rd_data_r;
  logic [IDX_W-1:0]       hold_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits stand in for a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // read data keeps tracking writes to the held address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hold_addr_r <= rd_addr;
      if (wr_en && wr_addr == rd_addr) begin
        rd_data_r <= wr_data;
      end else if (!vld_r[rd_addr]) begin
        rd_data_r <= 2'b00;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end else if (wr_en && wr_addr == hold_addr_r) begin
      rd_data_r <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tnrp_parser.sv
// tnrp_parser: telnet byte state machine, negotiation and subnegotiation handling
`timescale 1ns / 1ps
module tnrp_parser
  import tnrp_pkg::*;
#(
  parameter int NUM_OPTIONS = 64,
  parameter int IDX_W = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic [1:0]       tbl_data,
  input  cfg_t             cfg,
  output bundle_t          bundle,
  output logic             tbl_wr_en,
  output logic [IDX_W-1:0] tbl_wr_addr,
  output logic [1:0]       tbl_wr_data
);

  typedef enum logic [2:0] {
    ST_NORMAL, ST_IAC, ST_OPTNEG, ST_SBOPT, ST_SB, ST_SBIAC
  } pst_t;

  pst_t        state_r, state_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  opt_r, opt_nxt;
  logic        acc_r, acc_nxt;
  logic [11:0] cnt_r, cnt_nxt;

  function automatic logic [11:0] sat_add(logic [11:0] c, logic [1:0] inc);
    logic [12:0] s;
    s = {1'b0, c} + {11'd0, inc};
    return (s > 13'd4095) ? 12'd4095 : s[11:0];
  endfunction

  always_comb begin
    logic [1:0] n;
    logic       known;
    logic       remote;
    logic       want;
    logic       cur;
    logic       en;
    logic       sup;
    logic       full;
    logic [1:0] new_ent;

    n         = 2'd0;
    bundle    = '0;
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    opt_nxt   = opt_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = rx_byte[IDX_W-1:0];
    tbl_wr_data = tbl_data;

    known  = ({1'b0, rx_byte} < 9'(NUM_OPTIONS)) && (rx_byte[7:6] == 2'b00)
             && cfg.registered[rx_byte[5:0]];
    remote = (cmd_r == B_WILL) || (cmd_r == B_WONT);
    want   = (cmd_r == B_WILL) || (cmd_r == B_DO);
    cur    = remote ? tbl_data[1] : tbl_data[0];
    sup    = (rx_byte[7:6] == 2'b00)
             && (remote ? cfg.remote_sup[rx_byte[5:0]] : cfg.local_sup[rx_byte[5:0]]);
    en     = want && sup;
    full   = (cfg.subneg_lim != 12'd0) && (cnt_r >= cfg.subneg_lim);
    new_ent = tbl_data;
    if (remote) begin
      new_ent[1] = en;
    end else begin
      new_ent[0] = en;
    end

    case (state_r)
      ST_NORMAL: begin
        if (rx_byte == B_IAC) begin
          state_nxt = ST_IAC;
        end else begin
          bundle.item[n] = mk_res(K_DATA, rx_byte, 8'd0, E_NONE);
          n = n + 2'd1;
        end
      end
      ST_IAC: begin
        if (rx_byte == B_WILL || rx_byte == B_WONT || rx_byte == B_DO
            || rx_byte == B_DONT) begin
          cmd_nxt   = rx_byte;
          state_nxt = ST_OPTNEG;
        end else if (rx_byte == B_SB) begin
          cmd_nxt   = rx_byte;
          state_nxt = ST_SBOPT;
        end else begin
          if (rx_byte == B_IAC) begin
            bundle.item[n] = mk_res(K_DATA, rx_byte, 8'd0, E_NONE);
            n = n + 2'd1;
          end else if (rx_byte == B_SE) begin
            bundle.item[n] = mk_res(K_ERR, rx_byte, 8'd0, E_BADSB);
            n = n + 2'd1;
          end else if (rx_byte == B_GA) begin
            bundle.item[n] = mk_res(K_ERR, rx_byte, 8'd0, E_GA);
            n = n + 2'd1;
          end else if (rx_byte == B_AYT) begin
            bundle.item[n] = mk_res(K_AYT, rx_byte, 8'd0, E_NONE);
            n = n + 2'd1;
          end else if (rx_byte != B_DM && rx_byte >= B_SE
                       && cfg.cmd_events[rx_byte[3:0]]) begin
            bundle.item[n] = mk_res(K_EVENT, rx_byte, 8'd0, E_NONE);
            n = n + 2'd1;
          end
          state_nxt = ST_NORMAL;
          cmd_nxt   = 8'd0;
          opt_nxt   = 8'd0;
          acc_nxt   = 1'b0;
          cnt_nxt   = 12'd0;
        end
      end
      ST_OPTNEG: begin
        if (known) begin
          if (want != cur) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_data = new_ent;
            bundle.item[n] = mk_res(K_REPLY, rx_byte,
                                    remote ? (en ? B_DO : B_DONT) : (en ? B_WILL : B_WONT),
                                    E_NONE);
            n = n + 2'd1;
          end
        end else begin
          bundle.item[n] = mk_res(K_ERR, rx_byte, 8'd0, E_UNKNOWN);
          n = n + 2'd1;
          if (want) begin
            bundle.item[n] = mk_res(K_REPLY, rx_byte, remote ? B_DONT : B_WONT, E_NONE);
            n = n + 2'd1;
          end
        end
        state_nxt = ST_NORMAL;
        cmd_nxt   = 8'd0;
        opt_nxt   = 8'd0;
        acc_nxt   = 1'b0;
        cnt_nxt   = 12'd0;
      end
      ST_SBOPT: begin
        opt_nxt = rx_byte;
        acc_nxt = known && cfg.subneg_sup[rx_byte[5:0]] && (tbl_data != 2'b00);
        if (!acc_nxt) begin
          bundle.item[n] = mk_res(K_ERR, rx_byte, 8'd0, E_BADSB);
          n = n + 2'd1;
        end
        cnt_nxt   = 12'd0;
        state_nxt = ST_SB;
      end
      ST_SB: begin
        if (rx_byte == B_IAC) begin
          state_nxt = ST_SBIAC;
        end else if (full) begin
          bundle.item[n] = mk_res(K_ERR, opt_r, 8'd0, E_OVERFLOW);
          n = n + 2'd1;
          state_nxt = ST_NORMAL;
          cmd_nxt   = 8'd0;
          opt_nxt   = 8'd0;
          acc_nxt   = 1'b0;
          cnt_nxt   = 12'd0;
        end else begin
          cnt_nxt = sat_add(cnt_r, 2'd1);
          if (acc_r) begin
            bundle.item[n] = mk_res(K_SBYTE, rx_byte, 8'd0, E_NONE);
            n = n + 2'd1;
          end
        end
      end
      ST_SBIAC: begin
        if (rx_byte == B_SE || full) begin
          if (rx_byte == B_SE) begin
            if (acc_r) begin
              bundle.item[n] = mk_res(K_SEND, opt_r, 8'd0, E_NONE);
              n = n + 2'd1;
            end
          end else begin
            bundle.item[n] = mk_res(K_ERR, opt_r, 8'd0, E_OVERFLOW);
            n = n + 2'd1;
          end
          state_nxt = ST_NORMAL;
          cmd_nxt   = 8'd0;
          opt_nxt   = 8'd0;
          acc_nxt   = 1'b0;
          cnt_nxt   = 12'd0;
        end else begin
          // escaped or stray 0xff, a stray command byte follows it
          if (acc_r) begin
            bundle.item[n] = mk_res(K_SBYTE, B_IAC, 8'd0, E_NONE);
            n = n + 2'd1;
          end
          if (rx_byte != B_IAC) begin
            bundle.item[n] = mk_res(K_ERR, rx_byte, 8'd0, E_STRAY);
            n = n + 2'd1;
            if (acc_r) begin
              bundle.item[n] = mk_res(K_SBYTE, rx_byte, 8'd0, E_NONE);
              n = n + 2'd1;
            end
            cnt_nxt = sat_add(cnt_r, 2'd2);
          end else begin
            cnt_nxt = sat_add(cnt_r, 2'd1);
          end
          state_nxt = ST_SB;
        end
      end
      default: begin
        state_nxt = ST_NORMAL;
        cmd_nxt   = 8'd0;
        opt_nxt   = 8'd0;
        acc_nxt   = 1'b0;
        cnt_nxt   = 12'd0;
      end
    endcase
    bundle.cnt = n;
    tbl_wr_en  = tbl_wr_en & fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
      cmd_r   <= 8'd0;
      opt_r   <= 8'd0;
      acc_r   <= 1'b0;
      cnt_r   <= 12'd0;
    end else if (fire) begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      opt_r   <= opt_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/tnrp_result_buf.sv
// tnrp_result_buf: holds the results of one byte and hands them out one beat at a time
`timescale 1ns / 1ps
module tnrp_result_buf
  import tnrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_reply_command,
  output logic [2:0] out_err_code,
  output logic       out_last
);

  res_t [MAX_RES-1:0] items_r;
  logic [1:0]         cnt_r;
  logic [1:0]         idx_r;
  logic               is_last;
  logic               drain;

  assign out_valid = (cnt_r != 2'd0);
  assign is_last   = (idx_r + 2'd1 == cnt_r);
  assign drain     = out_valid && !out_stall;
  assign ready     = !out_valid || (drain && is_last);

  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= bundle.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
      idx_r <= 2'd0;
    end else if (drain) begin
      if (is_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  assign out_kind          = items_r[idx_r].kind;
  assign out_value         = items_r[idx_r].value;
  assign out_reply_command = items_r[idx_r].reply;
  assign out_err_code      = items_r[idx_r].err;
  assign out_last          = is_last;

endmodule

>>> rtl/telnet_receive_parser.sv
// telnet_receive_parser: top level of the telnet receive byte parser
`timescale 1ns / 1ps
//
//  channel   direction  ports                                       handshake
//  in        input      in_rx_byte                                  in_valid / in_stall
//  out       output     out_kind out_value out_reply_command        out_valid / out_stall
//                       out_err_code out_last
//  cfg       input      cfg_index cfg_wdata                         cfg_wr_en
//
//  while out_stall is low, a byte is taken every cycle if each byte gives at most
//  one result, and a byte that gives k results holds the output for k beats, as the
//  result buffer hands out one beat per cycle. option table read is issued at input
//  accept and its registered data is used by the parser when the byte in the holding
//  stage fires. synchronous reset clears the parser, the option table valid bits and
//  the configuration registers; there is no clearing pass. out_stall backs up into
//  in_stall within the same cycle once the holding stage is full.
//
module telnet_receive_parser
  import tnrp_pkg::*;
#(
  parameter int NUM_OPTIONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [7:0]  out_reply_command,
  output logic [2:0]  out_err_code,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int IDX_W = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             in_accept;
  logic             fire;
  logic             buf_ready;
  logic [1:0]       tbl_data;
  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  logic [1:0]       tbl_wr_data;
  bundle_t          bundle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REGISTERED: cfg_r.registered <= cfg_wdata;
        REG_LOCAL_SUP:  cfg_r.local_sup  <= cfg_wdata;
        REG_REMOTE_SUP: cfg_r.remote_sup <= cfg_wdata;
        REG_SUBNEG_SUP: cfg_r.subneg_sup <= cfg_wdata;
        REG_SUBNEG_LIM: cfg_r.subneg_lim <= cfg_wdata[11:0];
        REG_CMD_EVENTS: cfg_r.cmd_events <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // holding stage: byte waits here while its table entry is read
  assign fire      = s1_valid_r && buf_ready;
  assign in_stall  = s1_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // local / remote enabled bits per option
  tnrp_opt_mem #(
    .NUM_OPTIONS (NUM_OPTIONS),
    .IDX_W       (IDX_W)
  ) u_opt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_rx_byte[IDX_W-1:0]),
    .rd_data (tbl_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  // parse, negotiate and build the results of one byte
  tnrp_parser #(
    .NUM_OPTIONS (NUM_OPTIONS),
    .IDX_W       (IDX_W)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (s1_byte_r),
    .tbl_data    (tbl_data),
    .cfg         (cfg_r),
    .bundle      (bundle),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data)
  );

  // up to three results per byte, one beat per cycle while out_stall is low
  tnrp_result_buf u_result_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (fire),
    .bundle            (bundle),
    .ready             (buf_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_reply_command (out_reply_command),
    .out_err_code      (out_err_code),
    .out_last          (out_last)
  );

endmodule
